[rtl/binary_heap_priority_queue_core_defines.svh]
// assertion macros for the binary heap priority queue core
// used by the top level only, no other dependencies
`ifndef BINARY_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BHPQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap core check failed");
`define BHPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap core check failed");
`else
`define BHPQ_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BHPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/bhpq_pkg.sv]
// types, constants and the priority compare for the binary heap priority queue
// no dependencies
package bhpq_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [15:0] prio;
      logic [15:0]        id;
   } entry_type;

   typedef enum logic [2:0] {
      RD_ROOT,
      RD_LAST,
      RD_PARENT,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_READ,
      S_UP_CMP,
      S_RM_ROOT,
      S_RM_LAST,
      S_DN_READL,
      S_DN_READR,
      S_DN_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       take_root;
      logic       take_last;
      logic       wr_ent;
      logic       up_step;
      logic       save_left;
      logic       dn_step;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic req_remove;
      logic full;
      logic empty;
      logic at_root;
      logic last_gone;
      logic left_out;
      logic right_in;
      logic up_move;
      logic dn_move;
      logic out_busy;
   } sts_type;

   function automatic logic outranks(logic signed [15:0] a, logic signed [15:0] b,
                                     logic mode);
      outranks = mode ? (a > b) : (a < b);
   endfunction

endpackage

[rtl/bhpq_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module bhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bhpq_ctrl.sv]
// sequencing state machine for insert with sift up and remove with sift down
// depends on bhpq_pkg
module bhpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  bhpq_pkg::sts_type sts,
   output bhpq_pkg::cmd_type cmd
);

   import bhpq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (sts.req_remove && !sts.empty) begin
                  state_in = S_RM_ROOT;
               end else if (!sts.req_remove && !sts.full) begin
                  state_in = S_UP_READ;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_UP_READ:  state_in = sts.at_root ? S_FINISH : S_UP_CMP;
         S_UP_CMP:   state_in = sts.up_move ? S_UP_READ : S_FINISH;
         S_RM_ROOT:  state_in = S_RM_LAST;
         S_RM_LAST:  state_in = sts.last_gone ? S_FINISH : S_DN_READL;
         S_DN_READL: state_in = sts.left_out ? S_FINISH : S_DN_READR;
         S_DN_READR: state_in = S_DN_CMP;
         S_DN_CMP:   state_in = sts.dn_move ? S_DN_READL : S_FINISH;
         S_FINISH: begin
            if (!sts.out_busy) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_ROOT;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            cmd.rd_en  = req_tvalid && sts.req_remove && !sts.empty;
            cmd.rd_sel = RD_ROOT;
         end
         S_UP_READ: begin
            cmd.wr_ent = sts.at_root;
            cmd.rd_en  = !sts.at_root;
            cmd.rd_sel = RD_PARENT;
         end
         S_UP_CMP: begin
            cmd.up_step = 1'b1;
         end
         S_RM_ROOT: begin
            cmd.take_root = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_LAST;
         end
         S_RM_LAST: begin
            cmd.take_last = 1'b1;
         end
         S_DN_READL: begin
            cmd.wr_ent = sts.left_out;
            cmd.rd_en  = !sts.left_out;
            cmd.rd_sel = RD_LEFT;
         end
         S_DN_READR: begin
            cmd.save_left = 1'b1;
            cmd.rd_en     = sts.right_in;
            cmd.rd_sel    = RD_RIGHT;
         end
         S_DN_CMP: begin
            cmd.dn_step = 1'b1;
         end
         S_FINISH: begin
            cmd.rsp_load = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/bhpq_dp.sv]
// datapath: heap store, entry count, moving entry, sift compares, result register
// depends on bhpq_pkg and bhpq_ram
module bhpq_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic              csr_wdata,
   input  logic              req_tuser,
   input  logic [31:0]       req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   input  bhpq_pkg::cmd_type cmd,
   output bhpq_pkg::sts_type sts
);

   import bhpq_pkg::*;

   logic             heap_mode_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] pos_ff;
   entry_type        ent_ff;
   entry_type        child_ff;
   entry_type        removed_ff;
   status_type       status_ff;
   logic             rsp_valid_ff;
   logic [39:0]      rsp_data_ff;
   logic [1:0]       rsp_user_ff;

   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0]       rd_data;
   entry_type         rd_entry;
   entry_type         wr_entry;
   logic              wr_en;
   logic [CNT_W:0]    two_pos;
   logic [CNT_W:0]    two_pos_p1;
   logic [CNT_W:0]    count_wide;
   logic [CNT_W-1:0]  parent_pos;
   logic              right_in;
   logic              up_move;
   logic              left_wins;
   logic              right_wins;
   entry_type         mid;
   entry_type         cand;
   logic [CNT_W:0]    child_pos;

   assign rd_entry   = entry_type'(rd_data);
   assign two_pos    = {pos_ff, 1'b0};
   assign two_pos_p1 = two_pos + (CNT_W+1)'(1);
   assign count_wide = {1'b0, count_ff};
   assign parent_pos = pos_ff >> 1;
   assign right_in   = (two_pos_p1 <= count_wide);

   assign up_move    = outranks(ent_ff.prio, rd_entry.prio, heap_mode_ff);
   assign left_wins  = outranks(child_ff.prio, ent_ff.prio, heap_mode_ff);
   assign mid        = left_wins ? child_ff : ent_ff;
   assign right_wins = right_in && outranks(rd_entry.prio, mid.prio, heap_mode_ff);
   assign cand       = right_wins ? rd_entry : mid;
   assign child_pos  = right_wins ? two_pos_p1 : two_pos;

   always_comb begin
      case (cmd.rd_sel)
         RD_ROOT:   rd_addr = '0;
         RD_LAST:   rd_addr = ADDR_W'(count_ff - CNT_W'(1));
         RD_PARENT: rd_addr = ADDR_W'(parent_pos - CNT_W'(1));
         RD_LEFT:   rd_addr = ADDR_W'(two_pos - (CNT_W+1)'(1));
         RD_RIGHT:  rd_addr = ADDR_W'(two_pos);
         default:   rd_addr = '0;
      endcase
   end

   assign wr_addr = ADDR_W'(pos_ff - CNT_W'(1));
   assign wr_en   = cmd.wr_ent || cmd.up_step || cmd.dn_step;

   always_comb begin
      wr_entry = ent_ff;
      if (cmd.up_step && up_move) begin
         wr_entry = rd_entry;
      end else if (cmd.dn_step && (left_wins || right_wins)) begin
         wr_entry = cand;
      end
   end

   bhpq_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_mode_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            heap_mode_ff <= csr_wdata;
         end
         if (cmd.accept && req_tuser == OP_INSERT && count_ff != CNT_W'(CAPACITY)) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.take_last) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ent_ff     <= entry_type'(req_tdata);
         removed_ff <= '0;
         pos_ff     <= count_ff + CNT_W'(1);
         if (req_tuser == OP_INSERT) begin
            status_ff <= (count_ff == CNT_W'(CAPACITY)) ? ST_FULL : ST_OK;
         end else begin
            status_ff <= (count_ff == '0) ? ST_EMPTY : ST_OK;
         end
      end
      if (cmd.take_root) begin
         removed_ff <= rd_entry;
      end
      if (cmd.take_last) begin
         ent_ff <= rd_entry;
         pos_ff <= CNT_W'(1);
      end
      if (cmd.up_step && up_move) begin
         pos_ff <= parent_pos;
      end
      if (cmd.save_left) begin
         child_ff <= rd_entry;
      end
      if (cmd.dn_step && (left_wins || right_wins)) begin
         pos_ff <= child_pos[CNT_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_user_ff <= status_ff;
         rsp_data_ff <= {1'b0, count_ff, removed_ff.prio, removed_ff.id};
      end
   end

   always_comb begin
      sts.req_remove = (req_tuser == OP_REMOVE);
      sts.full       = (count_ff == CNT_W'(CAPACITY));
      sts.empty      = (count_ff == '0);
      sts.at_root    = (pos_ff == CNT_W'(1));
      sts.last_gone  = (count_ff == CNT_W'(1));
      sts.left_out   = (two_pos > count_wide);
      sts.right_in   = right_in;
      sts.up_move    = up_move;
      sts.dn_move    = left_wins || right_wins;
      sts.out_busy   = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[rtl/binary_heap_priority_queue_core.sv]
// top level of the binary heap priority queue core
// depends on bhpq_pkg, bhpq_ctrl, bhpq_dp and the defines header
//
// one request item in, one response item out. a request is an insert of a
// (priority, id) entry or a remove of the root entry; heap_mode picks whether
// the smallest or the largest priority sits at the root, written through csr_*
// while the core is idle: the user must keep to this, the core does not enforce
// it. the heap holds up to 64 entries in one ram with a registered read port,
// shared by all sift steps. a rejected insert or remove goes straight to finish;
// an insert climbs one level per parent read and compare until it reaches the
// root or a compare stops it, 6 levels at most; a remove reads the root and last
// entry, then descends one level per left and right child read and compare until
// a leaf or a compare stops it, 5 levels at most. the response turns valid as
// the core returns to idle; one item is in work at a time over the single ram port.
// req_tready is high only while idle; the next item may be taken while the
// previous response still waits in the output register. if rsp_tready stays
// low the core holds its finished result and waits before returning to idle.
// reset (synchronous) empties the heap and sets heap_mode to 0; the ram needs
// no clearing pass since only written positions are read.
`include "binary_heap_priority_queue_core_defines.svh"

module binary_heap_priority_queue_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,     // heap_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // item_id [15:0], priority_req [31:16]
   input  logic        req_tuser,     // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // removed_id [15:0], removed_priority [31:16],
                                      // entry_count_out [38:32], zero [39]
   output logic [1:0]  rsp_tuser      // status
);

   import bhpq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bhpq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

   `BHPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `BHPQ_ASSERT_SAME(a_full_count, clock, reset, rsp_tvalid && rsp_tuser == ST_FULL, rsp_tdata[38:32] == 7'(CAPACITY))
   `BHPQ_ASSERT_SAME(a_empty_zero, clock, reset, rsp_tvalid && rsp_tuser == ST_EMPTY, rsp_tdata[38:0] == '0)
   `BHPQ_ASSERT_SAME(a_port_split, clock, reset, cmd.rd_en, !(cmd.wr_ent || cmd.up_step || cmd.dn_step))

endmodule
